// ----- hw/rtl/dcwf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcwf_pkg
// Shared types and constants of the DDS command word formatter.
// ----------------------------------------------------------------------------
package dcwf_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned DvdW   = 60;  // freq_hz << 28
  localparam int unsigned DvsW   = 32;
  localparam int unsigned QuoW   = 28;  // only the low tuning-word bits are kept
  localparam int unsigned HalfW  = 14;
  localparam int unsigned PhaseW = 12;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned QDepth = 2;

  // request types
  localparam logic [1:0] REQ_CTRL_BIT = 2'd0;
  localparam logic [1:0] REQ_FREQ     = 2'd1;
  localparam logic [1:0] REQ_PHASE    = 2'd2;
  localparam logic [1:0] REQ_RESET    = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BASE_CLOCK = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FREQ   = 8'd1;

  localparam logic [31:0] BaseClockReset = 32'd50000000;
  localparam logic [31:0] MaxFreqReset   = 32'd50000000;

  localparam int unsigned   ResetBit      = 8;
  localparam int unsigned   TuneShift     = 28;
  localparam logic [15:0]   FreqPrefix0   = 16'h4000;
  localparam logic [15:0]   FreqPrefix1   = 16'h8000;
  localparam logic [15:0]   PhasePrefix0  = 16'hC000;
  localparam logic [15:0]   PhasePrefix1  = 16'hE000;
  localparam logic [12:0]   PhaseClampQ4  = 13'd5760;  // 360 degrees in Q12.4
  localparam logic [DvsW-1:0] PhaseDivisor = 32'd360;

  // scaled / 360 = (scaled >> 3) / 45, done as a multiply by ceil(2^24 / 45)
  localparam logic [18:0]   PhaseRecip      = 19'd372828;
  localparam int unsigned   PhaseRecipShift = 24;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        bank_select;
    logic [3:0]  bit_index;
    logic        bit_value;
    logic [31:0] freq_hz;
    logic [15:0] phase_deg_q4;
  } in_item_t;

  typedef struct packed {
    logic [15:0] serial_word;
    logic        last_word;
    logic        rejected;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_CTRL  = 2'd0,
    JOB_FREQ  = 2'd1,
    JOB_PHASE = 2'd2,
    JOB_RESET = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic             rejected;
    logic [WordW-1:0] ctrl0;
    logic [WordW-1:0] ctrl1;
    logic [WordW-1:0] prefix;
    logic [DvdW-1:0]  dividend;
    logic [DvsW-1:0]  divisor;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hw/rtl/dcwf_front.sv -----
// ----------------------------------------------------------------------------
// dcwf_front
// Accepts commands, keeps the control word and config registers, builds jobs.
// ----------------------------------------------------------------------------
module dcwf_front import dcwf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               push,
  input  logic               full,
  output job_t               push_job
);

  logic [WordW-1:0] ctrl_r, ctrl_nxt;
  logic [31:0]      base_r, max_r;
  logic [12:0]      phase_c;
  logic [24:0]      phase_prod;
  logic [WordW-1:0] bit_mask;
  logic [WordW-1:0] rst_mask;

  assign in_ready  = ~full;
  assign cfg_ready = 1'b1;
  assign push      = in_valid & ~full;

  assign bit_mask = WordW'(1) << in_data.bit_index;
  assign rst_mask = WordW'(1) << ResetBit;

  // phase * 4095 as (phase << 12) - phase
  assign phase_c    = (in_data.phase_deg_q4 > 16'(PhaseClampQ4)) ? PhaseClampQ4
                                                                 : in_data.phase_deg_q4[12:0];
  assign phase_prod = {phase_c, 12'b0} - 25'(phase_c);

  always_comb begin
    ctrl_nxt          = ctrl_r;
    push_job.kind     = JOB_CTRL;
    push_job.rejected = 1'b0;
    push_job.ctrl0    = ctrl_r;
    push_job.ctrl1    = ctrl_r;
    push_job.prefix   = in_data.bank_select ? FreqPrefix1 : FreqPrefix0;
    push_job.dividend = {in_data.freq_hz, TuneShift'(0)};
    push_job.divisor  = (base_r == '0) ? DvsW'(1) : base_r;
    case (in_data.req_type)
      REQ_CTRL_BIT: begin
        ctrl_nxt       = in_data.bit_value ? (ctrl_r | bit_mask) : (ctrl_r & ~bit_mask);
        push_job.ctrl0 = ctrl_nxt;
      end
      REQ_FREQ: begin
        if (in_data.freq_hz > max_r) begin
          push_job.rejected = 1'b1;
        end else begin
          push_job.kind = JOB_FREQ;
        end
      end
      REQ_PHASE: begin
        // scaled phase rides in the dividend field; the back divides by 360
        push_job.kind     = JOB_PHASE;
        push_job.prefix   = in_data.bank_select ? PhasePrefix1 : PhasePrefix0;
        push_job.dividend = DvdW'(phase_prod[24:4]);
      end
      default: begin
        push_job.kind  = JOB_RESET;
        push_job.ctrl0 = ctrl_r | rst_mask;
        push_job.ctrl1 = ctrl_r & ~rst_mask;
        ctrl_nxt       = ctrl_r & ~rst_mask;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      base_r <= BaseClockReset;
      max_r  <= MaxFreqReset;
    end else begin
      if (push) begin
        ctrl_r <= ctrl_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE_CLOCK: base_r <= cfg_data;
          CFG_MAX_FREQ:   max_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/dcwf_queue.sv -----
// ----------------------------------------------------------------------------
// dcwf_queue
// Small job FIFO between front and back.
// ----------------------------------------------------------------------------
module dcwf_queue import dcwf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t            mem_r [QDepth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] cnt_r;

  assign full    = (cnt_r == CntW'(QDepth));
  assign valid   = (cnt_r != '0);
  assign pop_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PtrW'(QDepth - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PtrW'(QDepth - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(push) - CntW'(pop);
    end
  end

endmodule

// ----- hw/rtl/dcwf_divider.sv -----
// ----------------------------------------------------------------------------
// dcwf_divider
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// ----------------------------------------------------------------------------
module dcwf_divider import dcwf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  input  logic [DvsW-1:0] divisor,
  output div_stat_t       stat,
  output logic [QuoW-1:0] quotient
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd_r;
  logic [DvsW-1:0] dvs_r;
  logic [DvsW-1:0] rem_r;
  logic [QuoW-1:0] quo_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            q_bit;

  assign trial = {rem_r, dvd_r[DvdW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign q_bit = ~diff[DvsW];   // no borrow: trial >= divisor

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= q_bit ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_r <= {quo_r[QuoW-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DvdW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/dcwf_back.sv -----
// ----------------------------------------------------------------------------
// dcwf_back
// Takes jobs, runs the divide, sequences the words into the output register.
// ----------------------------------------------------------------------------
module dcwf_back import dcwf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  job_t            q_job,
  output logic            q_pop,
  output logic            div_start,
  output logic [DvdW-1:0] div_dividend,
  output logic [DvsW-1:0] div_divisor,
  input  div_stat_t       div_stat,
  input  logic [QuoW-1:0] div_quo,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [WordW-1:0] words_r [3];
  logic [WordW-1:0] words_nxt [3];
  logic [1:0]       idx_r, idx_nxt;
  logic [1:0]       last_r, last_nxt;
  logic             rej_r, rej_nxt;
  logic [WordW-1:0] prefix_r, prefix_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             load;
  logic [17:0]      ph_scaled8;
  logic [36:0]      ph_prod;
  logic [PhaseW-1:0] ph_code;

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign div_dividend = q_job.dividend;
  assign div_divisor  = q_job.divisor;
  assign load         = ~out_valid_r | out_ready;

  // phase code: floor(scaled / 360) by reciprocal multiply
  assign ph_scaled8 = q_job.dividend[20:3];
  assign ph_prod    = 37'(ph_scaled8) * 37'(PhaseRecip);
  assign ph_code    = ph_prod[PhaseRecipShift +: PhaseW];

  always_comb begin
    state_nxt     = state_r;
    words_nxt     = words_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    rej_nxt       = rej_r;
    prefix_nxt    = prefix_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          prefix_nxt   = q_job.prefix;
          rej_nxt      = q_job.rejected;
          words_nxt[0] = q_job.ctrl0;
          words_nxt[1] = q_job.ctrl1;
          idx_nxt      = '0;
          case (q_job.kind)
            JOB_CTRL: begin
              last_nxt  = 2'd0;
              state_nxt = ST_EMIT;
            end
            JOB_PHASE: begin
              words_nxt[1] = q_job.prefix | WordW'(ph_code);
              last_nxt     = 2'd1;
              state_nxt    = ST_EMIT;
            end
            JOB_RESET: begin
              last_nxt  = 2'd1;
              state_nxt = ST_EMIT;
            end
            default: begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          words_nxt[1] = prefix_r | WordW'(div_quo[HalfW-1:0]);
          words_nxt[2] = prefix_r | WordW'(div_quo[2*HalfW-1:HalfW]);
          last_nxt     = 2'd2;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.serial_word = words_r[idx_r];
          out_data_nxt.last_word   = (idx_r == last_r);
          out_data_nxt.rejected    = rej_r;
          idx_nxt                  = idx_r + 1'b1;
          if (idx_r == last_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    words_r    <= words_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    rej_r      <= rej_nxt;
    prefix_r   <= prefix_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/dds_command_word_formatter.sv -----
// ----------------------------------------------------------------------------
// dds_command_word_formatter
// Turns DDS commands into 16-bit serial words (control, frequency, phase).
// ----------------------------------------------------------------------------
// One command goes in per in_ beat and gives one to three out_ beats, the last
// one marked by last_word. Bit updates, reset pulses, rejected frequencies and
// phase writes pass from the job queue through the back's state register into
// the output register; the phase code comes from a reciprocal multiply.
// Frequency writes go through a restoring divider that makes one quotient bit
// per cycle over 60 steps before their first word is sent; that divider sets
// the pace. Words then follow one per cycle while out_ready is high. The front
// takes up to two commands ahead into a job queue while the back works, and
// the back sends words through an output register, so either side may stall
// on its own. Config writes (cfg_ beats) are always taken and must only come
// while the block is idle.
module dds_command_word_formatter import dcwf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  // front -> queue
  logic push, full;
  job_t push_job;
  // queue -> back
  logic q_valid, q_pop;
  job_t q_job;
  // back <-> divider
  logic            div_start;
  logic [DvdW-1:0] div_dividend;
  logic [DvsW-1:0] div_divisor;
  div_stat_t       div_stat;
  logic [QuoW-1:0] div_quo;

  dcwf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .push_job  (push_job)
  );

  dcwf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (q_job)
  );

  // tuning word: (freq << 28) / base clock
  dcwf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  dcwf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_stat     (div_stat),
    .div_quo      (div_quo),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dds_command_word_formatter.
// ----------------------------------------------------------------------------
// Commands go in on in_ beats and the words that come back on out_ beats are
// checked in order against an in-bench prediction. That prediction keeps its
// own copy of the control word and of both registers. It works out each word
// in full: bit updates, tuning words from the 60/32 divide, clamped phase
// words, reset pulses and frequencies that are over the limit.
// Both sides idle at random. One long output stall fills the block up, and
// register writes are made only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import dcwf_pkg::*;

  // no beat for this long means the block is hung; the slowest legal gap is
  // the long output hold or one divide plus stalled words
  localparam int unsigned HangLimit     = 3000;
  localparam int unsigned SettleCycles  = 80;   // > one full divide
  localparam int unsigned LongHold      = 300;
  localparam int unsigned PhaseFullCode = 4095;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]     cfg_data;

  // predicted block state
  logic [15:0]     ctrl_word_model;
  logic [31:0]     base_clock_model;
  logic [31:0]     max_freq_model;

  // words still owed by the block, oldest first
  out_item_t       expected_words[$];

  // traffic shaping
  bit              idle_on;
  int unsigned     sink_gap;    // per-word stall drawn by the checker
  int unsigned     sink_hold;   // long stall requested by a test

  int unsigned     fail_count;
  int unsigned     quiet_cycles;
  int unsigned     words_checked;
  int unsigned     cmd_count[4];
  int unsigned     reject_count;
  int unsigned     cfg_writes;

  dds_command_word_formatter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void owe_word(logic [15:0] w, logic last, logic rej);
    expected_words.push_back(out_item_t'{serial_word: w, last_word: last, rejected: rej});
  endfunction

  // Works out every word one accepted command produces and queues them.
  function automatic void predict_words(in_item_t c);
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [27:0] tune;
    logic [15:0] prefix;
    int unsigned phase_q4;
    int unsigned scaled;
    logic [11:0] phase_code;
    case (c.req_type)
      REQ_CTRL_BIT: begin
        ctrl_word_model[c.bit_index] = c.bit_value;
        owe_word(ctrl_word_model, 1'b1, 1'b0);
      end
      REQ_FREQ: begin
        if (c.freq_hz > max_freq_model) begin
          // over the limit: control word only, flagged, state untouched
          owe_word(ctrl_word_model, 1'b1, 1'b1);
          reject_count++;
        end else begin
          // a zero base clock divides by one
          divisor  = (base_clock_model == 32'd0) ? 64'd1 : {32'd0, base_clock_model};
          dividend = {32'd0, c.freq_hz} << TuneShift;
          tune     = 28'(dividend / divisor);
          prefix   = c.bank_select ? FreqPrefix1 : FreqPrefix0;
          owe_word(ctrl_word_model, 1'b0, 1'b0);
          owe_word(prefix | {2'b00, tune[HalfW-1:0]}, 1'b0, 1'b0);
          owe_word(prefix | {2'b00, tune[QuoW-1:HalfW]}, 1'b1, 1'b0);
        end
      end
      REQ_PHASE: begin
        // phase saturates at a full turn
        phase_q4   = (c.phase_deg_q4 > PhaseClampQ4) ? PhaseClampQ4 : c.phase_deg_q4;
        scaled     = (phase_q4 * PhaseFullCode) >> 4;
        phase_code = 12'(scaled / PhaseDivisor);
        prefix     = c.bank_select ? PhasePrefix1 : PhasePrefix0;
        owe_word(ctrl_word_model, 1'b0, 1'b0);
        owe_word(prefix | {4'h0, phase_code}, 1'b1, 1'b0);
      end
      default: begin
        // reset pulse: bit set on the first word, cleared on the second
        ctrl_word_model[ResetBit] = 1'b1;
        owe_word(ctrl_word_model, 1'b0, 1'b0);
        ctrl_word_model[ResetBit] = 1'b0;
        owe_word(ctrl_word_model, 1'b1, 1'b0);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      sink_gap = idle_on ? $urandom_range(0, 4) : 0;
      if (expected_words.size() == 0) begin
        $error("unexpected word %h (last %0b rejected %0b)",
               out_data.serial_word, out_data.last_word, out_data.rejected);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_data.serial_word !== exp_w.serial_word) begin
          $error("serial_word: expected %h, got %h", exp_w.serial_word, out_data.serial_word);
          fail_count++;
        end
        if (out_data.last_word !== exp_w.last_word) begin
          $error("last_word: expected %0b, got %0b", exp_w.last_word, out_data.last_word);
          fail_count++;
        end
        if (out_data.rejected !== exp_w.rejected) begin
          $error("rejected: expected %0b, got %0b", exp_w.rejected, out_data.rejected);
          fail_count++;
        end
      end
    end
  end

  // Receiver: a long hold first, then the per-word stall, else ready.
  always begin
    @(negedge clk);
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hang detector: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HangLimit) begin
      $display("timeout: no beat for %0d cycles, %0d words outstanding",
               HangLimit, expected_words.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks (inputs change at the falling edge)
  // --------------------------------------------------------------------------
  // Sends one command; valid stays up across back-to-back beats.
  task automatic send_cmd(in_item_t c);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= c;
    do begin
      @(posedge clk);
    end while (!in_ready);
    cmd_count[c.req_type]++;
    predict_words(c);
  endtask

  // Sender pause: drop valid, wait for every owed word, then let the
  // divider run out before anything else happens.
  task automatic wait_block_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      CFG_BASE_CLOCK: base_clock_model = val;
      CFG_MAX_FREQ:   max_freq_model   = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random command; unused fields stay random so they are shown to be ignored.
  function automatic in_item_t random_cmd();
    in_item_t c;
    c.req_type     = 2'($urandom_range(0, 3));
    c.bank_select  = 1'($urandom);
    c.bit_index    = 4'($urandom);
    c.bit_value    = 1'($urandom);
    case ($urandom_range(0, 3))
      0:       c.freq_hz = $urandom;
      1:       c.freq_hz = max_freq_model + 32'($urandom_range(0, 4)) - 32'd2;
      default: c.freq_hz = $urandom_range(0, max_freq_model);
    endcase
    case ($urandom_range(0, 3))
      0:       c.phase_deg_q4 = 16'($urandom);
      1:       c.phase_deg_q4 = 16'($urandom_range(5700, 5800));
      default: c.phase_deg_q4 = 16'($urandom_range(0, PhaseClampQ4));
    endcase
    return c;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] kind);
    in_item_t c;
    c          = random_cmd();
    c.req_type = kind;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_control_bits();
    in_item_t c;
    c = make_cmd(REQ_CTRL_BIT); c.bit_index = 4'd0;  c.bit_value = 1'b1; send_cmd(c);
    c = make_cmd(REQ_CTRL_BIT); c.bit_index = 4'd15; c.bit_value = 1'b1; send_cmd(c);
    c = make_cmd(REQ_CTRL_BIT); c.bit_index = 4'd8;  c.bit_value = 1'b1; send_cmd(c);
    c = make_cmd(REQ_CTRL_BIT); c.bit_index = 4'd7;  c.bit_value = 1'b1; send_cmd(c);
    c = make_cmd(REQ_CTRL_BIT); c.bit_index = 4'd0;  c.bit_value = 1'b0; send_cmd(c);
  endtask

  // bit 8 is already set from the bit test, so the pulse clears it
  task automatic test_reset_pulse();
    send_cmd(make_cmd(REQ_RESET));
    send_cmd(make_cmd(REQ_RESET));
  endtask

  // Runs at the reset register values: 50 MHz clock and limit.
  task automatic test_frequency_words();
    in_item_t c;
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd0;          c.bank_select = 1'b0; send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd1;          c.bank_select = 1'b0; send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd49_999_999; c.bank_select = 1'b1; send_cmd(c);
    // exactly at the limit: tuning word wraps to zero
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd50_000_000; send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd50_000_001; send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'hFFFF_FFFF;  send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd12_345_678; c.bank_select = 1'b1; send_cmd(c);
  endtask

  task automatic test_phase_words();
    in_item_t c;
    c = make_cmd(REQ_PHASE); c.phase_deg_q4 = 16'd0;    c.bank_select = 1'b0; send_cmd(c);
    c = make_cmd(REQ_PHASE); c.phase_deg_q4 = 16'd1;    c.bank_select = 1'b1; send_cmd(c);
    c = make_cmd(REQ_PHASE); c.phase_deg_q4 = 16'd5759; send_cmd(c);
    c = make_cmd(REQ_PHASE); c.phase_deg_q4 = 16'd5760; send_cmd(c);
    // above a full turn saturates
    c = make_cmd(REQ_PHASE); c.phase_deg_q4 = 16'd5761; send_cmd(c);
    c = make_cmd(REQ_PHASE); c.phase_deg_q4 = 16'hFFFF; c.bank_select = 1'b1; send_cmd(c);
    c = make_cmd(REQ_PHASE); c.phase_deg_q4 = 16'd2880; c.bank_select = 1'b1; send_cmd(c);
  endtask

  task automatic test_register_extremes();
    in_item_t c;
    // zero base clock divides by one; full-scale limit accepts everything
    wait_block_idle();
    write_reg(CFG_BASE_CLOCK, 32'd0);
    write_reg(CFG_MAX_FREQ, 32'hFFFF_FFFF);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'hFFFF_FFFF; send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd3;         send_cmd(c);
    wait_block_idle();
    write_reg(CFG_BASE_CLOCK, 32'hFFFF_FFFF);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'hFFFF_FFFF; send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'h8000_0001; send_cmd(c);
    // zero limit: only a zero frequency passes
    wait_block_idle();
    write_reg(CFG_BASE_CLOCK, 32'd1);
    write_reg(CFG_MAX_FREQ, 32'd0);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd0; send_cmd(c);
    c = make_cmd(REQ_FREQ); c.freq_hz = 32'd1; send_cmd(c);
    wait_block_idle();
  endtask

  // Long receiver hold while the sender keeps offering back to back, so
  // the job queue and output register fill and in_ready drops.
  task automatic test_output_backpressure();
    in_item_t c;
    write_reg(CFG_BASE_CLOCK, 32'd100_000_000);
    write_reg(CFG_MAX_FREQ, 32'd40_000_000);
    idle_on   = 1'b0;
    sink_hold = LongHold;
    for (int i = 0; i < 16; i++) begin
      c = random_cmd();
      send_cmd(c);
    end
    wait_block_idle();
    idle_on = 1'b1;
  endtask

  // Random phases, each with its own register setting; part of every phase
  // runs without idling on either side.
  task automatic test_random_traffic();
    logic [31:0] base_clk;
    logic [31:0] limit;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          base_clk = $urandom_range(1_000_000, 200_000_000);
          limit    = $urandom_range(0, base_clk);
        end
        1: begin
          base_clk = $urandom;
          limit    = $urandom;
        end
        2: begin
          base_clk = $urandom_range(1, 1000);
          limit    = $urandom_range(0, 10_000);
        end
        default: begin
          base_clk = BaseClockReset;
          limit    = MaxFreqReset;
        end
      endcase
      wait_block_idle();
      write_reg(CFG_BASE_CLOCK, base_clk);
      write_reg(CFG_MAX_FREQ, limit);
      for (int i = 0; i < 110; i++) begin
        idle_on = ((i / 40) % 3) != 2;
        send_cmd(random_cmd());
      end
    end
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_ready        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    ctrl_word_model  = '0;
    base_clock_model = BaseClockReset;
    max_freq_model   = MaxFreqReset;
    idle_on          = 1'b1;
    sink_gap         = 0;
    sink_hold        = 0;
    fail_count       = 0;
    quiet_cycles     = 0;
    words_checked    = 0;
    reject_count     = 0;
    cfg_writes       = 0;
    for (int k = 0; k < 4; k++) cmd_count[k] = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_control_bits();
    test_reset_pulse();
    test_frequency_words();
    test_phase_words();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    // drain, then give stray words time to show up
    wait_block_idle();

    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      fail_count++;
    end
    $display("covered %0d bit updates, %0d frequency writes (%0d over limit), %0d phase writes,",
             cmd_count[REQ_CTRL_BIT], cmd_count[REQ_FREQ], reject_count, cmd_count[REQ_PHASE]);
    $display("  %0d reset pulses, %0d register writes, %0d words checked",
             cmd_count[REQ_RESET], cfg_writes, words_checked);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
